### src/bslb_pkg.sv
// ----------------------------------------------------------------------------
// bslb_pkg
// Shared types and constants of the bidirectional scan line binner.
// ----------------------------------------------------------------------------
package bslb_pkg;

  localparam int unsigned MAX_PIXELS = 4096;
  localparam int unsigned MAX_LINES  = 4096;
  localparam int unsigned MAX_BIN    = 64;

  // Register limits can hold the maximum itself, positions run to max - 1.
  localparam int unsigned PIX_LIM_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LINE_LIM_W = $clog2(MAX_LINES + 1);
  localparam int unsigned BIN_LIM_W  = $clog2(MAX_BIN + 1);
  localparam int unsigned PIX_POS_W  = $clog2(MAX_PIXELS);
  localparam int unsigned LINE_POS_W = $clog2(MAX_LINES);
  localparam int unsigned BIN_POS_W  = $clog2(MAX_BIN);

  // Fixed field widths.
  localparam int unsigned PIX_REG_W  = 13;
  localparam int unsigned LINE_REG_W = 13;
  localparam int unsigned BIN_REG_W  = 7;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COLUMN_W   = 12;
  localparam int unsigned LINE_W     = 12;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned MEAN_W     = 22;

  // Mean = sum * 64 / bin: 8 fraction bits after dividing by bin * 4.
  // The whole scaled sum is divided; the mean keeps the low quotient bits.
  localparam int unsigned FRAC_SHIFT = 6;
  localparam int unsigned DIV_W      = SUM_W + FRAC_SHIFT;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE        = 2'd2;

  localparam logic [PIX_REG_W-1:0]  PIX_RESET  = 13'd512;
  localparam logic [LINE_REG_W-1:0] LINE_RESET = 13'd512;
  localparam logic [BIN_REG_W-1:0]  BIN_RESET  = 7'd1;

  // Effective register limits after clamping.
  typedef struct packed {
    logic [PIX_LIM_W-1:0]  pix;
    logic [LINE_LIM_W-1:0] lines;
    logic [BIN_LIM_W-1:0]  bin;
  } cfg_t;

  // One finished reverse-line bin waiting for its division.
  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [LINE_W-1:0]   line;
    logic [SUM_W-1:0]    sum;
  } bin_rec_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

### src/bslb_front.sv
// ----------------------------------------------------------------------------
// bslb_front
// Sample counting and bin accumulation; emits one record per reverse-line bin.
// ----------------------------------------------------------------------------
module bslb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bslb_pkg::cfg_t                cfg_i,
  input  logic                          accept_i,
  input  logic [bslb_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          rec_push_o,
  output bslb_pkg::bin_rec_t            rec_o
);

  logic [bslb_pkg::BIN_POS_W-1:0]  bin_pos_q, bin_pos_d;
  logic [bslb_pkg::PIX_POS_W-1:0]  pix_pos_q, pix_pos_d;
  logic [bslb_pkg::LINE_POS_W-1:0] line_pos_q, line_pos_d;
  logic [bslb_pkg::SUM_W-1:0]      sum_q, sum_d;

  logic [bslb_pkg::BIN_POS_W-1:0]  bin_c;
  logic [bslb_pkg::PIX_POS_W-1:0]  pix_c;
  logic [bslb_pkg::LINE_POS_W-1:0] line_c;
  logic [bslb_pkg::BIN_LIM_W-1:0]  bin_last;
  logic [bslb_pkg::PIX_LIM_W-1:0]  pix_last;
  logic [bslb_pkg::LINE_LIM_W-1:0] line_last;
  logic [bslb_pkg::SUM_W-1:0]      sum_next;
  logic                            reverse;
  logic                            bin_end;
  logic                            pix_end;
  logic                            line_end;

  always_comb begin
    bin_last  = cfg_i.bin - 1'b1;
    pix_last  = cfg_i.pix - 1'b1;
    line_last = cfg_i.lines - 1'b1;

    // Pull positions back inside limits that shrank since the last item.
    bin_c  = ({1'b0, bin_pos_q} >= cfg_i.bin) ?
             bin_last[bslb_pkg::BIN_POS_W-1:0] : bin_pos_q;
    pix_c  = ({1'b0, pix_pos_q} >= cfg_i.pix) ?
             pix_last[bslb_pkg::PIX_POS_W-1:0] : pix_pos_q;
    line_c = ({1'b0, line_pos_q} >= cfg_i.lines) ?
             line_last[bslb_pkg::LINE_POS_W-1:0] : line_pos_q;

    reverse  = line_c[0];
    bin_end  = ({1'b0, bin_c} == bin_last);
    pix_end  = ({1'b0, pix_c} == pix_last);
    line_end = ({1'b0, line_c} == line_last);
    sum_next = sum_q + bslb_pkg::SUM_W'(sample_i);

    bin_pos_d  = bin_c;
    pix_pos_d  = pix_c;
    line_pos_d = line_c;
    sum_d      = reverse ? sum_next : sum_q;
    if (bin_end) begin
      bin_pos_d = '0;
      sum_d     = '0;
      if (pix_end) begin
        pix_pos_d  = '0;
        line_pos_d = line_end ? '0 : line_c + 1'b1;
      end else begin
        pix_pos_d = pix_c + 1'b1;
      end
    end else begin
      bin_pos_d = bin_c + 1'b1;
    end
  end

  always_comb begin
    rec_push_o    = accept_i && reverse && bin_end;
    rec_o.column  = bslb_pkg::COLUMN_W'(pix_last - bslb_pkg::PIX_LIM_W'(pix_c));
    rec_o.line    = bslb_pkg::LINE_W'(line_c - 1'b1);
    rec_o.sum     = sum_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_pos_q  <= '0;
      pix_pos_q  <= '0;
      line_pos_q <= '0;
      sum_q      <= '0;
    end else if (accept_i) begin
      bin_pos_q  <= bin_pos_d;
      pix_pos_q  <= pix_pos_d;
      line_pos_q <= line_pos_d;
      sum_q      <= sum_d;
    end
  end

endmodule

### src/bslb_queue.sv
// ----------------------------------------------------------------------------
// bslb_queue
// Short first-in first-out queue of bin records between front and back.
// ----------------------------------------------------------------------------
module bslb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bslb_pkg::bin_rec_t wdata_i,
  input  logic               pop_i,
  output bslb_pkg::bin_rec_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  bslb_pkg::bin_rec_t                entries_q [bslb_pkg::QUEUE_DEPTH];
  logic [bslb_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bslb_pkg::QUEUE_CNT_W-1:0]  count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == bslb_pkg::QUEUE_CNT_W'(bslb_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### src/bslb_back.sv
// ----------------------------------------------------------------------------
// bslb_back
// Bit-serial divider for the bin mean and the result output register.
// ----------------------------------------------------------------------------
module bslb_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [bslb_pkg::BIN_LIM_W-1:0]       bin_i,
  input  logic                                 q_empty_i,
  input  bslb_pkg::bin_rec_t                   q_rec_i,
  output logic                                 q_pop_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic [bslb_pkg::COLUMN_W-1:0]        column_o,
  output logic [bslb_pkg::LINE_W-1:0]          pair_first_line_o,
  output logic [bslb_pkg::MEAN_W-1:0]          mean_value_o
);

  bslb_pkg::back_state_e state_q, state_d;

  logic [bslb_pkg::BIN_LIM_W-1:0] rem_q;
  logic [bslb_pkg::DIV_W-1:0]     quo_q;
  logic [bslb_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [bslb_pkg::COLUMN_W-1:0]  col_q;
  logic [bslb_pkg::LINE_W-1:0]    line_q;
  logic                           out_valid_q;

  logic [bslb_pkg::BIN_LIM_W:0]   trial;
  logic [bslb_pkg::BIN_LIM_W:0]   diff;
  logic                           ge;
  logic                           last_step;
  logic                           slot_free;
  logic                           load_out;
  logic                           div_step;

  assign empty_o   = !out_valid_q;
  assign slot_free = !out_valid_q || pop_i;
  assign last_step = (cnt_q == bslb_pkg::DIV_CNT_W'(bslb_pkg::DIV_STEPS - 1));

  // Restoring division: remainder stays below bin, quotient shifts in at bottom.
  always_comb begin
    trial = {rem_q, quo_q[bslb_pkg::DIV_W-1]};
    diff  = trial - {1'b0, bin_i};
    ge    = (trial >= {1'b0, bin_i});
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bslb_pkg::BK_IDLE: if (!q_empty_i) state_d = bslb_pkg::BK_DIV;
      bslb_pkg::BK_DIV:  if (last_step) state_d = bslb_pkg::BK_DONE;
      bslb_pkg::BK_DONE: if (slot_free) state_d = bslb_pkg::BK_IDLE;
      default:           state_d = bslb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    case (state_q)
      bslb_pkg::BK_IDLE: q_pop_o  = !q_empty_i;
      bslb_pkg::BK_DIV:  div_step = 1'b1;
      bslb_pkg::BK_DONE: load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bslb_pkg::BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        cnt_q <= '0;
      end else if (div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shift the whole scaled sum through, so the remainder starts at zero; the
  // mean keeps the low quotient bits.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rem_q  <= '0;
      quo_q  <= {q_rec_i.sum, bslb_pkg::FRAC_SHIFT'(0)};
      col_q  <= q_rec_i.column;
      line_q <= q_rec_i.line;
    end else if (div_step) begin
      rem_q <= ge ? diff[bslb_pkg::BIN_LIM_W-1:0] : trial[bslb_pkg::BIN_LIM_W-1:0];
      quo_q <= {quo_q[bslb_pkg::DIV_W-2:0], ge};
    end
    if (load_out) begin
      column_o          <= col_q;
      pair_first_line_o <= line_q;
      mean_value_o      <= quo_q[bslb_pkg::MEAN_W-1:0];
    end
  end

endmodule

### src/bidirectional_scan_line_binner_top.sv
// ----------------------------------------------------------------------------
// bidirectional_scan_line_binner_top
// Bins bidirectional scan samples into mirrored pixel means per line pair.
// ----------------------------------------------------------------------------
// The front takes one sample per cycle whenever its record queue (4 entries)
// has room; while it is full every sample waits, forward lines and partial
// bins too. Each finished reverse-line bin is divided by the bit-serial
// divider in the back, one result at a time: one pop, 28 division steps and
// one handoff to the output register, which waits while that is still full.
// With small bins the queue fills on reverse lines and the front then stalls
// until the divider frees an entry. Configuration writes are taken at once.
module bidirectional_scan_line_binner_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [bslb_pkg::SAMPLE_W-1:0]         sample_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [bslb_pkg::COLUMN_W-1:0]         column_o,
  output logic [bslb_pkg::LINE_W-1:0]           pair_first_line_o,
  output logic [bslb_pkg::MEAN_W-1:0]           mean_value_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bslb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bslb_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [bslb_pkg::PIX_REG_W-1:0]  pix_reg_q;
  logic [bslb_pkg::LINE_REG_W-1:0] line_reg_q;
  logic [bslb_pkg::BIN_REG_W-1:0]  bin_reg_q;
  bslb_pkg::cfg_t                  cfg;
  bslb_pkg::bin_rec_t              rec_in, rec_out;
  logic                            rec_push, q_pop, q_full, q_empty, accept;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_reg_q  <= bslb_pkg::PIX_RESET;
      line_reg_q <= bslb_pkg::LINE_RESET;
      bin_reg_q  <= bslb_pkg::BIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bslb_pkg::REG_PIXELS_PER_LINE: pix_reg_q  <= bslb_pkg::PIX_REG_W'(cfg_data_i);
        bslb_pkg::REG_LINES_PER_FRAME: line_reg_q <= bslb_pkg::LINE_REG_W'(cfg_data_i);
        bslb_pkg::REG_BIN_SIZE:        bin_reg_q  <= bslb_pkg::BIN_REG_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversized values saturate at the maximum.
  always_comb begin
    if (pix_reg_q == '0) begin
      cfg.pix = bslb_pkg::PIX_LIM_W'(1);
    end else if (bslb_pkg::PIX_REG_W'(pix_reg_q) > bslb_pkg::PIX_REG_W'(bslb_pkg::MAX_PIXELS)) begin
      cfg.pix = bslb_pkg::PIX_LIM_W'(bslb_pkg::MAX_PIXELS);
    end else begin
      cfg.pix = bslb_pkg::PIX_LIM_W'(pix_reg_q);
    end
    if (line_reg_q == '0) begin
      cfg.lines = bslb_pkg::LINE_LIM_W'(1);
    end else if (line_reg_q > bslb_pkg::LINE_REG_W'(bslb_pkg::MAX_LINES)) begin
      cfg.lines = bslb_pkg::LINE_LIM_W'(bslb_pkg::MAX_LINES);
    end else begin
      cfg.lines = bslb_pkg::LINE_LIM_W'(line_reg_q);
    end
    if (bin_reg_q == '0) begin
      cfg.bin = bslb_pkg::BIN_LIM_W'(1);
    end else if (bin_reg_q > bslb_pkg::BIN_REG_W'(bslb_pkg::MAX_BIN)) begin
      cfg.bin = bslb_pkg::BIN_LIM_W'(bslb_pkg::MAX_BIN);
    end else begin
      cfg.bin = bslb_pkg::BIN_LIM_W'(bin_reg_q);
    end
  end

  bslb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  bslb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .pop_i   (q_pop),
    .rdata_o (rec_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bslb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .bin_i             (cfg.bin),
    .q_empty_i         (q_empty),
    .q_rec_i           (rec_out),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .column_o          (column_o),
    .pair_first_line_o (pair_first_line_o),
    .mean_value_o      (mean_value_o)
  );

endmodule

### src/bslb_checker.sv
// ----------------------------------------------------------------------------
// bslb_checker
// Port-level checks of the binner's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bslb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [bslb_pkg::COLUMN_W-1:0]  column_o,
  input logic [bslb_pkg::LINE_W-1:0]    pair_first_line_o,
  input logic [bslb_pkg::MEAN_W-1:0]    mean_value_o
);

  // A waiting item holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(column_o) && $stable(pair_first_line_o)
                       && $stable(mean_value_o))
    else $error("result changed while waiting");

  // Results always name the even line of a pair.
  a_even_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !pair_first_line_o[0])
    else $error("pair_first_line is odd");

  // Leaving reset, nothing waits and input is open.
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> empty && !full)
    else $error("not clear after reset");

endmodule

bind bidirectional_scan_line_binner_top bslb_checker u_bslb_checker (.*);

### test/tb_bidirectional_scan_line_binner_top.sv
// ----------------------------------------------------------------------------
// tb_bidirectional_scan_line_binner_top
// Self-checking bench: feeds scan samples under changing line, frame and bin
// settings, predicts every mirrored pixel mean and checks each popped result.
// ----------------------------------------------------------------------------
module tb_bidirectional_scan_line_binner_top;
  import bslb_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_CYCLES = 300;
  localparam int BLOCK_ITEMS  = 500;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PACE_TX30_RX47,
    PACE_TX47_RX30,
    PACE_NO_GAPS
  } pace_e;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [LINE_W-1:0]   line;
    logic [MEAN_W-1:0]   mean;
  } pixel_mean_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  logic [SAMPLE_W-1:0]   sample_i    = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [COLUMN_W-1:0]   column_o;
  logic [LINE_W-1:0]     pair_first_line_o;
  logic [MEAN_W-1:0]     mean_value_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic  sink_hold = 1'b0;
  logic  stall_go  = 1'b0;
  pace_e pace      = PACE_TX30_RX47;

  logic [SAMPLE_W-1:0] sample_feed[$];
  pixel_mean_t         expected_means[$];
  int unsigned         mismatch_count = 0;

  // Mirror of the block's registers and counters.
  logic [PIX_REG_W-1:0]  cur_pix   = PIX_RESET;
  logic [LINE_REG_W-1:0] cur_lines = LINE_RESET;
  logic [BIN_REG_W-1:0]  cur_bin   = BIN_RESET;
  int unsigned           pos_bin   = 0;
  int unsigned           pos_pix   = 0;
  int unsigned           pos_line  = 0;
  logic [63:0]           bin_acc   = '0;

  bidirectional_scan_line_binner_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .sample_i          (sample_i),
    .empty             (empty),
    .pop               (pop),
    .column_o          (column_o),
    .pair_first_line_o (pair_first_line_o),
    .mean_value_o      (mean_value_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_limit(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("ERROR: %s", msg);
  endtask

  // Advance the binning counters by one sample; queue a mean on reverse bin ends.
  task automatic bin_sample(input logic [SAMPLE_W-1:0] smp);
    int unsigned pix_lim;
    int unsigned line_lim;
    int unsigned bin_lim;
    logic        reverse;
    logic        bin_done;
    logic [31:0] tmp;
    logic [63:0] quot;
    pixel_mean_t want;
    pix_lim  = clamp_limit(cur_pix, MAX_PIXELS);
    line_lim = clamp_limit(cur_lines, MAX_LINES);
    bin_lim  = clamp_limit(cur_bin, MAX_BIN);
    if (pos_bin >= bin_lim) pos_bin = bin_lim - 1;
    if (pos_pix >= pix_lim) pos_pix = pix_lim - 1;
    if (pos_line >= line_lim) pos_line = line_lim - 1;
    reverse  = pos_line[0];
    bin_done = (pos_bin + 1) >= bin_lim;
    if (reverse) begin
      bin_acc += smp;
      if (bin_done) begin
        tmp         = pix_lim - 1 - pos_pix;
        want.column = tmp[COLUMN_W-1:0];
        tmp         = pos_line - 1;
        want.line   = tmp[LINE_W-1:0];
        quot        = (bin_acc * 64) / bin_lim;
        want.mean   = quot[MEAN_W-1:0];
        expected_means.push_back(want);
      end
    end
    if (bin_done) begin
      bin_acc = '0;
      pos_bin = 0;
      pos_pix++;
      if (pos_pix >= pix_lim) begin
        pos_pix = 0;
        pos_line++;
        if (pos_line >= line_lim) pos_line = 0;
      end
    end else begin
      pos_bin++;
    end
  endtask

  function automatic logic sender_idles();
    case (pace)
      PACE_TX30_RX47: return $urandom_range(0, 99) < 30;
      PACE_TX47_RX30: return $urandom_range(0, 99) < 47;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_idles();
    case (pace)
      PACE_TX30_RX47: return $urandom_range(0, 99) < 47;
      PACE_TX47_RX30: return $urandom_range(0, 99) < 30;
      default:        return 1'b0;
    endcase
  endfunction

  // Sample driver: hold an item while full, load the next one once it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) bin_sample(sample_i);
      if (!push || !full) begin
        if (sample_feed.size() != 0 && !sender_idles()) begin
          push     <= 1'b1;
          sample_i <= sample_feed.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    pixel_mean_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("unexpected result column %0d line %0d mean %0d",
                                    column_o, pair_first_line_o, mean_value_o));
        end else begin
          want = expected_means.pop_front();
          if (column_o !== want.column)
            report_mismatch($sformatf("column %0d, want %0d", column_o, want.column));
          if (pair_first_line_o !== want.line)
            report_mismatch($sformatf("pair_first_line %0d, want %0d",
                                      pair_first_line_o, want.line));
          if (mean_value_o !== want.mean)
            report_mismatch($sformatf("mean_value %0d, want %0d (column %0d)",
                                      mean_value_o, want.mean, want.column));
        end
      end
      pop <= !sink_hold && !receiver_idles();
    end
  end

  // Long receiver hold-off so the block fills up and pushes back.
  initial begin
    wait (stall_go);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  task automatic wait_drained();
    do begin
      while (sample_feed.size() != 0 || push || expected_means.size() != 0)
        @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end while (sample_feed.size() != 0 || push || expected_means.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PIXELS_PER_LINE: cur_pix   = data[PIX_REG_W-1:0];
      REG_LINES_PER_FRAME: cur_lines = data[LINE_REG_W-1:0];
      REG_BIN_SIZE:        cur_bin   = data[BIN_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pix, input logic [CFG_DATA_W-1:0] lines,
                           input logic [CFG_DATA_W-1:0] bin_sz);
    wait_drained();
    write_reg(REG_PIXELS_PER_LINE, pix);
    write_reg(REG_LINES_PER_FRAME, lines);
    write_reg(REG_BIN_SIZE, bin_sz);
  endtask

  // Mostly 14-bit values shifted by two, with extremes and raw noise mixed in.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      2, 3:    return 16'($urandom);
      default: return {14'($urandom_range(0, 16383)), 2'b00};
    endcase
  endfunction

  task automatic random_phase(input int unsigned n);
    logic [CFG_DATA_W-1:0] pix_val;
    logic [CFG_DATA_W-1:0] lines_val;
    logic [CFG_DATA_W-1:0] bin_val;
    case ($urandom_range(0, 19))
      0:       pix_val = '0;
      1:       pix_val = 13'h1000;
      2:       pix_val = 13'h1FFF;
      3:       pix_val = 13'($urandom_range(9, 8191));
      default: pix_val = 13'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 19))
      0:       lines_val = '0;
      1:       lines_val = 13'd1;
      2:       lines_val = 13'($urandom_range(10, 8191));
      default: lines_val = 13'($urandom_range(2, 9));
    endcase
    case ($urandom_range(0, 19))
      0:       bin_val = '0;
      1:       bin_val = 13'd127;
      2:       bin_val = 13'($urandom_range(24, 64));
      3:       bin_val = 13'($urandom_range(5, 126));
      default: bin_val = 13'($urandom_range(1, 4));
    endcase
    // Upper data bits must be dropped by the bin register.
    if ($urandom_range(0, 3) == 0) bin_val[CFG_DATA_W-1:BIN_REG_W] = 6'($urandom_range(1, 63));
    wait_drained();
    if ($urandom_range(0, 3) != 0) write_reg(REG_PIXELS_PER_LINE, pix_val);
    if ($urandom_range(0, 3) != 0) write_reg(REG_LINES_PER_FRAME, lines_val);
    if ($urandom_range(0, 3) != 0) write_reg(REG_BIN_SIZE, bin_val);
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 13'($urandom));
    repeat (n) sample_feed.push_back(draw_sample());
  endtask

  task automatic random_block(input pace_e p);
    int unsigned fed;
    int unsigned n;
    pace = p;
    fed  = 0;
    while (fed < BLOCK_ITEMS) begin
      n = $urandom_range(20, 90);
      random_phase(n);
      fed += n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Short lines in an odd frame: trailing unpaired line, then wrap.
    configure(13'd2, 13'd3, 13'd1);
    sample_feed = {16'hFFFF, 16'h0000, 16'hFFFC, 16'h0004, 16'hAAAA,
                   16'h5555, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF};
    // Line position beyond a smaller frame lands on the last (reverse) line.
    configure(13'd1, 13'd2, 13'd3);
    sample_feed = {16'hFFFF, 16'hFFFF, 16'hFFFF};
    // Zero and oversized settings, unknown register index.
    wait_drained();
    write_reg(REG_UNUSED, 13'h1FFF);
    write_reg(REG_PIXELS_PER_LINE, 13'd0);
    write_reg(REG_LINES_PER_FRAME, 13'd0);
    write_reg(REG_BIN_SIZE, 13'h1FFF);
    sample_feed = {16'h1234, 16'hFFFF};
    // Widest line on a reverse line gives the top columns, then shrink it.
    configure(13'd1, 13'd2, 13'd1);
    sample_feed.push_back(16'h00FF);
    wait_drained();
    write_reg(REG_PIXELS_PER_LINE, 13'h1FFF);
    sample_feed = {16'hFFFC, 16'h0004};
    wait_drained();
    write_reg(REG_PIXELS_PER_LINE, 13'd2);
    sample_feed.push_back(16'h7FFC);
    // Bin shrunk in the middle of a reverse bin ends it at once.
    configure(13'd1, 13'd2, 13'd4);
    sample_feed = {16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    wait_drained();
    write_reg(REG_BIN_SIZE, 13'd2);
    sample_feed.push_back(16'hFFFF);

    // Back-pressure: reverse lines at bin one while the receiver holds off.
    configure(13'd4, 13'd2, 13'd1);
    stall_go = 1'b1;
    repeat (120) sample_feed.push_back(draw_sample());

    random_block(PACE_TX30_RX47);
    random_block(PACE_TX47_RX30);
    random_block(PACE_NO_GAPS);

    wait_drained();
    if (expected_means.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_means.size()));
    if (mismatch_count == 0) begin
      $display("bidirectional_scan_line_binner_top test passed");
    end else begin
      $display("bidirectional_scan_line_binner_top test failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 1_500_000);
    $display("bidirectional_scan_line_binner_top test failed");
    $finish;
  end

endmodule
